// File: design/xbd_pkg.sv
// Shared types and constants for the XTEA rolling-key block decryptor.
`default_nettype none
package xbd_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [WordW-1:0] XteaDelta = 32'h9E37_79B9;
	localparam logic [WordW-1:0] TopBit = 32'h8000_0000;
	localparam logic [WordW-1:0] LowBit = 32'h0000_0001;

	localparam logic [CfgIdxW-1:0] CFG_KEY0 = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_KEY1 = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_KEY2 = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_KEY3 = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_POLY = 3'd4;

	localparam logic CMD_DECRYPT = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	typedef logic [WordW-1:0] word_t;
	typedef logic [3:0][WordW-1:0] key_arr_t;

	typedef struct packed {
		logic                cfg_we;
		logic [CfgIdxW-1:0]  cfg_idx;
		word_t               cfg_data;
		logic                restart;
		logic                roll;
		word_t               roll_mix;
	} key_ctl_t;

endpackage
`default_nettype wire

// File: design/xbd_if.sv
// Channel interfaces: ciphertext input, plaintext output, register writes.
`default_nettype none
interface xbd_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [63:0] cipher_block;

	modport source (output valid, output command, output cipher_block, input ready);
	modport sink (input valid, input command, input cipher_block, output ready);
endinterface

interface xbd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] plain_block;

	modport source (output valid, output plain_block, input ready);
	modport sink (input valid, input plain_block, output ready);
endinterface

interface xbd_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [xbd_pkg::CfgIdxW-1:0]  index;
	logic [xbd_pkg::WordW-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: design/xbd_half_round.sv
// Shared XTEA half-round unit: target minus (mix(other) xor (sum plus key)).
`default_nettype none
module xbd_half_round (
	input  wire xbd_pkg::word_t target,
	input  wire xbd_pkg::word_t other,
	input  wire xbd_pkg::word_t sum,
	input  wire xbd_pkg::word_t key,
	output xbd_pkg::word_t      result
);

	xbd_pkg::word_t mix;
	xbd_pkg::word_t sk;

	always_comb begin
		mix = ((other << 4) ^ (other >> 5)) + other;
		sk = sum + key;
		result = target - (mix ^ sk);
	end

endmodule
`default_nettype wire

// File: design/xbd_keys.sv
// Configured key words, roll polynomial and the four running key words.
`default_nettype none
module xbd_keys (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire xbd_pkg::key_ctl_t  ctl,
	output xbd_pkg::key_arr_t       running
);

	xbd_pkg::key_arr_t cfg_key_q;
	xbd_pkg::word_t    poly_q;
	xbd_pkg::key_arr_t run_q;
	xbd_pkg::key_arr_t rolled;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if ((run_q[i] & xbd_pkg::TopBit) != '0) begin
				rolled[i] = ((run_q[i] ^ poly_q) << 1) | xbd_pkg::LowBit;
			end else begin
				rolled[i] = run_q[i] << 1;
			end
		end
		rolled[0] = rolled[0] ^ ctl.roll_mix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_key_q <= '0;
			poly_q <= '0;
			run_q <= '0;
		end else begin
			if (ctl.cfg_we) begin
				case (ctl.cfg_idx)
					xbd_pkg::CFG_KEY0, xbd_pkg::CFG_KEY1,
					xbd_pkg::CFG_KEY2, xbd_pkg::CFG_KEY3: begin
						cfg_key_q[ctl.cfg_idx[1:0]] <= ctl.cfg_data;
						run_q <= '0;
					end
					xbd_pkg::CFG_POLY: begin
						poly_q <= ctl.cfg_data;
					end
					default: begin
					end
				endcase
			end else if (ctl.restart) begin
				run_q <= cfg_key_q;
			end else if (ctl.roll) begin
				run_q <= rolled;
			end
		end
	end

	assign running = run_q;

endmodule
`default_nettype wire

// File: design/xtea_block_decrypt_rolling_key.sv
// Top level: XTEA block decryptor with rolling keys, half-round sequencer.
//
//   channel  | dir | handshake     | payload
//   cipher   | in  | valid / ready | command (1), cipher_block (64)
//   plain    | out | valid / ready | plain_block (64)
//   cfg      | in  | valid / ready | index (3), data (32)
//
// A decrypt steps through HALF1 and HALF2 after the transfer: one shared
// half-round unit runs two passes per Feistel round, then DONE waits for a
// free output register, loads it and rolls the keys. A restart reloads the running keys.
// The next item is taken while the result still waits in the output register.
// Reset clears all registers and running keys; cfg is always ready.
`default_nettype none
module xtea_block_decrypt_rolling_key #(
	parameter int unsigned ROUNDS = 32
) (
	input  wire       clk,
	input  wire       arst_n,
	xbd_in_if.sink    cipher,
	xbd_out_if.source plain,
	xbd_cfg_if.sink   cfg
);

	localparam int unsigned RndW = $clog2(ROUNDS + 1);
	localparam logic [63:0] SumProd = 64'(xbd_pkg::XteaDelta) * 64'(ROUNDS);
	localparam xbd_pkg::word_t SumInit = SumProd[31:0];
	localparam logic [RndW-1:0] RndLast = RndW'(ROUNDS - 1);
	localparam logic [RndW-1:0] RndStep = RndW'(1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_HALF1 = 2'd1;
	localparam logic [1:0] ST_HALF2 = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [RndW-1:0]   rnd_q;
	xbd_pkg::word_t    v0_q;
	xbd_pkg::word_t    v1_q;
	xbd_pkg::word_t    sum_q;
	logic              out_valid_q;
	logic [63:0]       out_data_q;

	xbd_pkg::key_arr_t running;
	xbd_pkg::key_ctl_t key_ctl;
	xbd_pkg::word_t    hr_target;
	xbd_pkg::word_t    hr_other;
	xbd_pkg::word_t    hr_key;
	xbd_pkg::word_t    hr_result;
	logic              in_xfer;
	logic              out_free;
	logic              finish;

	assign cipher.ready = (state_q == ST_IDLE);
	assign in_xfer = cipher.valid && cipher.ready;
	assign out_free = !out_valid_q || plain.ready;
	assign finish = (state_q == ST_DONE) && out_free;
	assign cfg.ready = 1'b1;

	always_comb begin
		if (state_q == ST_HALF2) begin
			hr_target = v0_q;
			hr_other = v1_q;
			hr_key = running[sum_q[1:0]];
		end else begin
			hr_target = v1_q;
			hr_other = v0_q;
			hr_key = running[sum_q[12:11]];
		end
	end

	xbd_half_round u_half (
		.target (hr_target),
		.other  (hr_other),
		.sum    (sum_q),
		.key    (hr_key),
		.result (hr_result)
	);

	always_comb begin
		key_ctl.cfg_we = cfg.valid && cfg.ready;
		key_ctl.cfg_idx = cfg.index;
		key_ctl.cfg_data = cfg.data;
		key_ctl.restart = in_xfer && (cipher.command == xbd_pkg::CMD_RESTART);
		key_ctl.roll = finish;
		key_ctl.roll_mix = v0_q;
	end

	xbd_keys u_keys (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (key_ctl),
		.running (running)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (plain.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && cipher.command == xbd_pkg::CMD_DECRYPT) begin
						rnd_q <= RndLast;
						state_q <= ST_HALF1;
					end
				end
				ST_HALF1: begin
					state_q <= ST_HALF2;
				end
				ST_HALF2: begin
					if (rnd_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						rnd_q <= rnd_q - RndStep;
						state_q <= ST_HALF1;
					end
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= '0;
			v1_q <= '0;
			sum_q <= '0;
			out_data_q <= '0;
		end else begin
			if (in_xfer) begin
				v0_q <= cipher.cipher_block[31:0];
				v1_q <= cipher.cipher_block[63:32];
				sum_q <= SumInit;
			end else if (state_q == ST_HALF1) begin
				v1_q <= hr_result;
				sum_q <= sum_q - xbd_pkg::XteaDelta;
			end else if (state_q == ST_HALF2) begin
				v0_q <= hr_result;
			end
			if (finish) begin
				out_data_q <= {v1_q, v0_q};
			end
		end
	end

	assign plain.valid = out_valid_q;
	assign plain.plain_block = out_data_q;

endmodule
`default_nettype wire
